/* src/tlf_pkg.sv */
package tlf_pkg;

  // Default line width; the segment store holds one byte more
  localparam int WIDTH_DEF = 20;
  localparam int CHAR_W    = 8;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NL     = 8'd10;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'd9;
  localparam logic [CHAR_W-1:0] CH_SP     = 8'd32;
  localparam logic [CHAR_W-1:0] CH_HYPHEN = 8'd45;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_HYPH,
    ST_NEWL
  } tlf_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // input transfer this cycle
    logic rd_issue;   // read next buffered byte
    logic load_data;  // move read data into the output register
    logic load_hyph;  // put a hyphen in the output register
    logic load_nl;    // put the closing newline in the output register
  } tlf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start;      // the byte on the input starts an emission burst
    logic done;       // no buffered bytes left to read
    logic hyph;       // burst ends with a hyphen before the newline
    logic out_free;   // output register can take a byte
  } tlf_stat_t;

endpackage

/* src/text_line_folder_core.sv */
// Channel  | Ports                         | Contents
// ---------+-------------------------------+----------------------------------
// in_      | tvalid tready tdata[7:0]      | one text byte
// out_     | tvalid tready tdata[7:0] tlast| folded text byte, tlast on final
//
// A byte that only joins the segment is written to the ring and starts no
// burst. A newline after a non-empty segment, or a fold, is accepted and then
// read back from the segment ring (registered read port): each buffered byte
// passes ST_READ then ST_LOAD, followed by an inserted hyphen if any and the
// closing newline. The output register lets the next byte in while the last
// result waits. Reset (rst_n low, synchronous) empties the segment; the
// buffer itself needs no clearing. A stalled output holds the burst.
module text_line_folder_core #(
  parameter int WIDTH = tlf_pkg::WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [tlf_pkg::CHAR_W-1:0] in_tdata,   // [7:0] char_in
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [tlf_pkg::CHAR_W-1:0] out_tdata,  // [7:0] char_out
  output logic                       out_tlast
);

  tlf_pkg::tlf_cmd_t  cmd;
  tlf_pkg::tlf_stat_t st;

  tlf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  tlf_dp #(
    .WIDTH(WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cmd       (cmd),
    .st        (st)
  );

`ifndef ASSERT_OFF
  // One action per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.rd_issue, cmd.load_data, cmd.load_hyph, cmd.load_nl}))
    else $error("more than one command at once");

  // Never overwrite a byte still waiting at the output
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_data || cmd.load_hyph || cmd.load_nl) |-> st.out_free)
    else $error("output register overwritten");

  // No input taken in the middle of a burst
  a_no_accept_mid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |=> !in_tready)
    else $error("input ready during emission");

  // Closing newline shows up flagged as last
  a_nl_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_nl |=> out_tvalid && out_tlast && out_tdata == tlf_pkg::CH_NL)
    else $error("closing newline missing");
`endif

endmodule

/* src/tlf_ram.sv */
module tlf_ram #(
  parameter int W = 8,
  parameter int D = 21
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/tlf_ctrl.sv */
module tlf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  tlf_pkg::tlf_stat_t st,
  output tlf_pkg::tlf_cmd_t  cmd
);

  tlf_pkg::tlf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tlf_pkg::ST_IDLE: begin
        if (in_tvalid && st.start) state_nxt = tlf_pkg::ST_READ;
      end
      tlf_pkg::ST_READ: begin
        state_nxt = tlf_pkg::ST_LOAD;
      end
      tlf_pkg::ST_LOAD: begin
        if (st.out_free) begin
          if (!st.done)    state_nxt = tlf_pkg::ST_READ;
          else if (st.hyph) state_nxt = tlf_pkg::ST_HYPH;
          else             state_nxt = tlf_pkg::ST_NEWL;
        end
      end
      tlf_pkg::ST_HYPH: begin
        if (st.out_free) state_nxt = tlf_pkg::ST_NEWL;
      end
      tlf_pkg::ST_NEWL: begin
        if (st.out_free) state_nxt = tlf_pkg::ST_IDLE;
      end
      default: state_nxt = tlf_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      tlf_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      tlf_pkg::ST_READ: cmd.rd_issue  = 1'b1;
      tlf_pkg::ST_LOAD: cmd.load_data = st.out_free;
      tlf_pkg::ST_HYPH: cmd.load_hyph = st.out_free;
      tlf_pkg::ST_NEWL: cmd.load_nl   = st.out_free;
      default: ;
    endcase
  end

endmodule

/* src/tlf_dp.sv */
module tlf_dp #(
  parameter int WIDTH = tlf_pkg::WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [tlf_pkg::CHAR_W-1:0] in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [tlf_pkg::CHAR_W-1:0] out_tdata,
  output logic                       out_tlast,
  input  tlf_pkg::tlf_cmd_t           cmd,
  output tlf_pkg::tlf_stat_t          st
);

  localparam int DEPTH = WIDTH + 1;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  // Ring position plus offset, wrapped once
  function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] base,
                                            input logic [CW-1:0] inc);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(inc);
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[PW-1:0];
  endfunction

  logic [PW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] blank_r, blank_nxt;     // rightmost blank past position 0, 0 if none
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] left_r, left_nxt;       // bytes still to read
  logic          hyph_r, hyph_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [tlf_pkg::CHAR_W-1:0] out_data_r, out_data_nxt;
  logic          out_last_r, out_last_nxt;

  logic                       is_nl, is_blank, is_full;
  logic [CW-1:0]              brk;
  logic                       ram_we;
  logic [PW-1:0]              ram_waddr;
  logic [tlf_pkg::CHAR_W-1:0] ram_rdata;

  assign is_nl    = (in_tdata == tlf_pkg::CH_NL);
  assign is_blank = (in_tdata == tlf_pkg::CH_SP) || (in_tdata == tlf_pkg::CH_TAB);
  assign is_full  = (count_r == CW'(WIDTH));
  assign brk      = is_blank ? CW'(WIDTH) : blank_r;

  assign ram_we    = cmd.accept && !is_nl;
  assign ram_waddr = ptr_add(head_r, count_r);

  tlf_ram #(
    .W(tlf_pkg::CHAR_W),
    .D(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(in_tdata),
    .re   (cmd.rd_issue),
    .raddr(rd_ptr_r),
    .rdata(ram_rdata)
  );

  // Segment bookkeeping
  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    blank_nxt  = blank_r;
    rd_ptr_nxt = rd_ptr_r;
    left_nxt   = left_r;
    hyph_nxt   = hyph_r;
    if (cmd.accept) begin
      if (is_nl) begin
        // flush the segment
        count_nxt  = '0;
        blank_nxt  = '0;
        rd_ptr_nxt = head_r;
        left_nxt   = count_r;
        hyph_nxt   = 1'b0;
      end else if (is_full) begin
        // fold: break after the rightmost blank, else split with a hyphen
        rd_ptr_nxt = head_r;
        blank_nxt  = '0;
        if (brk != '0) begin
          left_nxt  = brk + CW'(1);
          head_nxt  = ptr_add(head_r, brk + CW'(1));
          count_nxt = CW'(WIDTH) - brk;
          hyph_nxt  = 1'b0;
        end else begin
          left_nxt  = CW'(WIDTH - 1);
          head_nxt  = ptr_add(head_r, CW'(WIDTH - 1));
          count_nxt = CW'(2);
          hyph_nxt  = 1'b1;
        end
      end else begin
        count_nxt = count_r + CW'(1);
        if (is_blank && count_r != '0) blank_nxt = count_r;
      end
    end else if (cmd.rd_issue) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      left_nxt   = left_r - CW'(1);
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (cmd.load_data) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = ram_rdata;
      out_last_nxt  = 1'b0;
    end else if (cmd.load_hyph) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = tlf_pkg::CH_HYPHEN;
      out_last_nxt  = 1'b0;
    end else if (cmd.load_nl) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = tlf_pkg::CH_NL;
      out_last_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      blank_r     <= '0;
      rd_ptr_r    <= '0;
      left_r      <= '0;
      hyph_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      blank_r     <= blank_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      left_r      <= left_nxt;
      hyph_r      <= hyph_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid  = out_valid_r;
  assign out_tdata   = out_data_r;
  assign out_tlast   = out_last_r;

  assign st.start    = is_nl ? (count_r != '0) : is_full;
  assign st.done     = (left_r == '0);
  assign st.hyph     = hyph_r;
  assign st.out_free = !out_valid_r || out_tready;

endmodule
